FILE: sv/tlws_pkg.sv
`default_nettype none
package tlws_pkg;

    localparam int DEF_NUM_TASKS   = 3;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam int MISS_W  = 8;
    localparam int GRACE_W = 9;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [GRACE_W-1:0] GRACE_SAT = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE_TICKS = 1'b1;

    localparam logic [CFG_W-1:0] MISS_LIMIT_RST  = 8'd5;
    localparam logic [CFG_W-1:0] GRACE_TICKS_RST = 8'd2;

    typedef struct packed {
        logic [CFG_W-1:0] miss_limit;
        logic [CFG_W-1:0] grace_ticks;
    } cfg_t;

    typedef struct packed {
        logic              advance;
        logic              check;
        logic [MISS_W-1:0] limit;
    } lane_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/task_liveness_watchdog_supervisor.sv
// Task liveness watchdog supervisor.
// The s_ channel takes one supervision tick per item: s_tdata carries one
// liveness counter sample per supervised task. The m_ channel returns one
// result item per tick with the kick and stall flags, the sticky failsafe
// flag and each task's miss count after the tick.
// The cfg channel writes miss_limit (index 0) and grace_ticks (index 1); it
// is always ready and should only be written while no item is in flight.
// An accepted input waits in the input register, then its result in the
// result register: one input register and one result register with the
// compare and count logic between them.
// Throughput is one item per cycle while m_tready is high; the result register
// lets a new tick be taken while an earlier result still waits on m_tready.
// When m_tready is low the result holds, the input register fills, and then
// s_tready drops until the result is taken.
// A synchronous low on aresetn clears the grace counter, stored samples,
// miss counts and failsafe flag, empties both registers and restores
// miss_limit to 5 and grace_ticks to 2.
`default_nettype none
module task_liveness_watchdog_supervisor #(
    parameter int NUM_TASKS   = tlws_pkg::DEF_NUM_TASKS,
    parameter int SAMPLE_BITS = tlws_pkg::DEF_SAMPLE_BITS,
    localparam int IN_BITS    = NUM_TASKS * SAMPLE_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = 3 + tlws_pkg::MISS_W * NUM_TASKS,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Fields from bit 0 up: sample_a, sample_b, sample_c (one per task).
    input  wire logic [IN_W-1:0]                s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: kick, stall_now, failsafe_latched, miss_a,
    // miss_b, miss_c (one miss count per task).
    output logic [OUT_W-1:0]                    m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tlws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tlws_pkg::CFG_W-1:0]     cfg_data
);

    tlws_pkg::cfg_t                  cfg;
    tlws_pkg::lane_ctrl_t            lane_ctrl;

    logic                            in_valid_reg;
    logic [IN_BITS-1:0]              in_data_reg;
    logic                            out_valid_reg;
    logic [OUT_W-1:0]                out_data_reg;
    logic [OUT_W-1:0]                out_data_next;
    logic [tlws_pkg::GRACE_W-1:0]    grace_reg;
    logic [tlws_pkg::GRACE_W-1:0]    grace_next;
    logic                            failsafe_reg;
    logic                            failsafe_next;

    logic                            advance;
    logic                            load;
    logic                            is_grace;
    logic                            stall;
    logic                            kick;
    logic [NUM_TASKS-1:0]            alive;
    logic [tlws_pkg::MISS_W*NUM_TASKS-1:0] miss_flat;

    assign cfg_ready = 1'b1;

    tlws_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    assign grace_next = (grace_reg == tlws_pkg::GRACE_SAT) ?
                        grace_reg : grace_reg + tlws_pkg::GRACE_W'(1);
    assign is_grace   = grace_next <= {1'b0, cfg.grace_ticks};

    assign lane_ctrl.advance = advance;
    assign lane_ctrl.check   = !is_grace;
    assign lane_ctrl.limit   = cfg.miss_limit;

    for (genvar t = 0; t < NUM_TASKS; t++) begin : g_lane
        tlws_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl),
            .sample   (in_data_reg[t*SAMPLE_BITS +: SAMPLE_BITS]),
            .miss_res (miss_flat[t*tlws_pkg::MISS_W +: tlws_pkg::MISS_W]),
            .alive    (alive[t])
        );
    end

    assign stall         = !is_grace && !(&alive);
    assign kick          = !stall;
    assign failsafe_next = failsafe_reg || stall;

    always_comb begin
        out_data_next = '0;
        out_data_next[OUT_BITS-1:0] = {miss_flat, failsafe_next, stall, kick};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            grace_reg     <= '0;
            failsafe_reg  <= 1'b0;
        end else begin
            if (load) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                grace_reg     <= grace_next;
                failsafe_reg  <= failsafe_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_kick_xor_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[0] != out_data_reg[1]))
        else $error("result shows kick and stall together or neither");

    a_stall_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[1]) |-> out_data_reg[2])
        else $error("stall result without failsafe flag set");

    a_failsafe_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failsafe_reg |=> failsafe_reg)
        else $error("failsafe flag cleared without reset");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("item left input register but no result is pending");

    a_grace_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_grace) |-> kick)
        else $error("grace tick did not kick");
`endif

endmodule
`default_nettype wire

FILE: sv/tlws_cfg_regs.sv
`default_nettype none
module tlws_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic [tlws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tlws_pkg::CFG_W-1:0]     cfg_data,
    output tlws_pkg::cfg_t                      cfg
);

    tlws_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.miss_limit  <= tlws_pkg::MISS_LIMIT_RST;
            cfg_reg.grace_ticks <= tlws_pkg::GRACE_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tlws_pkg::CFG_MISS_LIMIT:  cfg_reg.miss_limit  <= cfg_data;
                tlws_pkg::CFG_GRACE_TICKS: cfg_reg.grace_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: sv/tlws_lane.sv
`default_nettype none
module tlws_lane #(
    parameter int SAMPLE_BITS = tlws_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tlws_pkg::lane_ctrl_t        ctrl,
    input  wire logic [SAMPLE_BITS-1:0]      sample,
    output logic [tlws_pkg::MISS_W-1:0]      miss_res,
    output logic                             alive
);

    logic [SAMPLE_BITS-1:0]        prev_reg;
    logic [tlws_pkg::MISS_W-1:0]   miss_reg;
    logic [tlws_pkg::MISS_W-1:0]   miss_next;

    always_comb begin
        if (sample == prev_reg) begin
            if (miss_reg < ctrl.limit) begin
                miss_next = miss_reg + tlws_pkg::MISS_W'(1);
            end else begin
                miss_next = ctrl.limit;
            end
        end else begin
            miss_next = '0;
        end
    end

    assign miss_res = ctrl.check ? miss_next : miss_reg;
    assign alive    = miss_next < ctrl.limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            miss_reg <= '0;
        end else if (ctrl.advance && ctrl.check) begin
            prev_reg <= sample;
            miss_reg <= miss_next;
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int TASKS  = tlws_pkg::DEF_NUM_TASKS;
    localparam int SBITS  = tlws_pkg::DEF_SAMPLE_BITS;
    localparam int IN_W   = ((TASKS * SBITS + 7) / 8) * 8;
    localparam int OUT_W  = ((3 + tlws_pkg::MISS_W * TASKS + 7) / 8) * 8;

    typedef logic [SBITS-1:0] sample_t;
    typedef logic [tlws_pkg::MISS_W-1:0] miss_t;

    typedef struct packed {
        miss_t miss_c;
        miss_t miss_b;
        miss_t miss_a;
        logic  latched;
        logic  stall;
        logic  kick;
    } verdict_t;

    class watchdog_scoreboard;
        logic [tlws_pkg::CFG_W-1:0]   miss_limit;
        logic [tlws_pkg::CFG_W-1:0]   grace_ticks;
        logic [tlws_pkg::GRACE_W-1:0] tick_count;
        sample_t                      last_sample [TASKS];
        miss_t                        miss [TASKS];
        logic                         latched;
        verdict_t                     verdict_q [$];
        int errors;
        int ticks;
        int grace_seen;
        int stalls;
        int highest_miss;
        int checked;

        function new();
            miss_limit   = tlws_pkg::MISS_LIMIT_RST;
            grace_ticks  = tlws_pkg::GRACE_TICKS_RST;
            tick_count   = '0;
            latched      = 1'b0;
            errors       = 0;
            ticks        = 0;
            grace_seen   = 0;
            stalls       = 0;
            highest_miss = 0;
            checked      = 0;
            for (int i = 0; i < TASKS; i++) begin
                last_sample[i] = '0;
                miss[i]        = '0;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void write_reg(logic [tlws_pkg::CFG_IDX_W-1:0] idx,
                                logic [tlws_pkg::CFG_W-1:0] value);
            if (idx == tlws_pkg::CFG_MISS_LIMIT) begin
                miss_limit = value;
            end else if (idx == tlws_pkg::CFG_GRACE_TICKS) begin
                grace_ticks = value;
            end
        endfunction

        function void note_tick(logic [IN_W-1:0] data);
            verdict_t v;
            sample_t  now;
            logic     all_alive;
            ticks++;
            if (tick_count != tlws_pkg::GRACE_SAT) begin
                tick_count = tick_count + 1'b1;
            end
            v.kick  = 1'b1;
            v.stall = 1'b0;
            if (tick_count <= {1'b0, grace_ticks}) begin
                grace_seen++;
            end else begin
                all_alive = 1'b1;
                for (int i = 0; i < TASKS; i++) begin
                    now = data[i*SBITS +: SBITS];
                    if (now == last_sample[i]) begin
                        miss[i] = (miss[i] < miss_limit) ? miss[i] + 1'b1 : miss_limit;
                    end else begin
                        miss[i] = '0;
                    end
                    last_sample[i] = now;
                    if (!(miss[i] < miss_limit)) begin
                        all_alive = 1'b0;
                    end
                    if (int'(miss[i]) > highest_miss) begin
                        highest_miss = int'(miss[i]);
                    end
                end
                if (!all_alive) begin
                    v.kick  = 1'b0;
                    v.stall = 1'b1;
                    latched = 1'b1;
                    stalls++;
                end
            end
            v.latched = latched;
            v.miss_a  = miss[0];
            v.miss_b  = miss[1];
            v.miss_c  = miss[2];
            verdict_q.push_back(v);
        endfunction

        task report(string field, longint got, longint want);
            $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                     checked, field, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] data);
            verdict_t got;
            verdict_t want;
            got = data[$bits(verdict_t)-1:0];
            checked++;
            if (verdict_q.size() == 0) begin
                report("unexpected item", 1, 0);
            end else begin
                want = verdict_q.pop_front();
                if (got.kick !== want.kick) report("kick", got.kick, want.kick);
                if (got.stall !== want.stall) report("stall_now", got.stall, want.stall);
                if (got.latched !== want.latched) begin
                    report("failsafe_latched", got.latched, want.latched);
                end
                if (got.miss_a !== want.miss_a) report("miss_a", got.miss_a, want.miss_a);
                if (got.miss_b !== want.miss_b) report("miss_b", got.miss_b, want.miss_b);
                if (got.miss_c !== want.miss_c) report("miss_c", got.miss_c, want.miss_c);
            end
        endtask
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic [IN_W-1:0]                 s_tdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [OUT_W-1:0]                m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tlws_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tlws_pkg::CFG_W-1:0]      cfg_data = '0;

    watchdog_scoreboard sb = new();

    sample_t counter [TASKS];
    int      hold_left [TASKS];
    int      burst_left = 0;
    int      cfg_writes = 0;
    int      rx_mode = 0;
    int      rx_left = 0;
    int      rx_phase = 0;

    task_liveness_watchdog_supervisor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_tick(s_tdata);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
        end
    end

    // The result side switches between always ready, random, sparse and
    // periodic stall patterns.
    always @(negedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= rx_phase[2];
        endcase
    end

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic send_tick(sample_t a, sample_t b, sample_t c);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({c, b, a});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_cycles($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic drain();
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [tlws_pkg::CFG_IDX_W-1:0] idx,
                             logic [tlws_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_regs(logic [tlws_pkg::CFG_W-1:0] limit,
                            logic [tlws_pkg::CFG_W-1:0] grace);
        drain();
        write_reg(tlws_pkg::CFG_MISS_LIMIT, limit);
        write_reg(tlws_pkg::CFG_GRACE_TICKS, grace);
    endtask

    // Each task mostly counts up, sometimes freezes for a run of ticks and
    // now and then jumps to an arbitrary value.
    task automatic run_phase(int n, int hold_chance, int max_run);
        int r;
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < TASKS; i++) begin
                if (hold_left[i] > 0) begin
                    hold_left[i]--;
                end else begin
                    r = $urandom_range(0, 15);
                    if (r < hold_chance) begin
                        hold_left[i] = $urandom_range(0, max_run - 1);
                    end else if (r == 15) begin
                        counter[i] = $urandom;
                    end else if (r == 14) begin
                        counter[i] = $urandom_range(0, 1) ? '1 : '0;
                    end else begin
                        counter[i] = counter[i] + $urandom_range(1, 3);
                    end
                end
            end
            send_tick(counter[0], counter[1], counter[2]);
            pace();
        end
    endtask

    initial begin
        for (int i = 0; i < TASKS; i++) begin
            counter[i]   = $urandom;
            hold_left[i] = 0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Boot grace ticks, then the first check against the zero reset samples.
        send_tick('1, 32'hAAAA_AAAA, 32'h5555_5555);
        send_tick($urandom, $urandom, $urandom);
        send_tick('0, '0, '0);
        send_tick('1, '1, '1);
        pace();
        repeat (5) send_tick('1, '1, '1);
        send_tick(32'hAAAA_AAAA, '1, 32'h5555_5555);
        idle_cycles(2);
        repeat (4) send_tick(32'hAAAA_AAAA, '0, 32'h5555_5555);

        // Lowering the limit clamps the counts that are already above it.
        set_regs(8'd2, tlws_pkg::GRACE_TICKS_RST);
        send_tick(32'hAAAA_AAAA, '0, 32'h5555_5555);

        // With a zero limit every check reports a stall.
        set_regs(8'd0, tlws_pkg::GRACE_TICKS_RST);
        send_tick(32'hAAAA_AAAA, '0, 32'h5555_5555);
        send_tick(32'h1234_5678, 32'h8765_4321, 32'h0F0F_F0F0);

        // Raising the grace count at run time brings back a few grace ticks.
        set_regs(8'd1, 8'd20);
        repeat (3) send_tick($urandom, $urandom, $urandom);
        send_tick(32'h0000_0001, 32'h8000_0000, 32'hDEAD_BEEF);
        send_tick(32'h0000_0001, 32'h8000_0000, 32'hDEAD_BEEF);

        set_regs(8'd3, 8'd0);
        run_phase(120, 3, 6);
        set_regs(8'd1, 8'd7);
        run_phase(100, 2, 3);
        // Past 255 ticks the grace window can no longer reopen.
        set_regs(8'd255, 8'd255);
        run_phase(170, 6, 180);
        set_regs(8'($urandom_range(2, 9)), 8'($urandom_range(1, 254)));
        run_phase(60, 3, 10);
        drain();
        run_phase(60, 3, 10);
        set_regs(8'd6, 8'($urandom_range(0, 255)));
        run_phase(140, 4, 9);

        drain();
        repeat (10) @(posedge aclk);
        $display("Ran %0d ticks (%0d in grace) through %0d register writes.",
                 sb.ticks, sb.grace_seen, cfg_writes);
        $display("Saw %0d stall ticks; highest miss count %0d; %0d results checked.",
                 sb.stalls, sb.highest_miss, sb.checked);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
